// ===== rtl/core/v4g_pkg.sv =====
package v4g_pkg;

  // Operation codes carried in the input tuser field
  typedef logic [2:0] func_t;
  localparam func_t FUNC_LEN  = 3'd0;
  localparam func_t FUNC_NORM = 3'd1;
  localparam func_t FUNC_DOT  = 3'd2;
  localparam func_t FUNC_REFL = 3'd3;
  localparam func_t FUNC_REFR = 3'd4;

  // Register depth of the square root pipeline: one register per root bit plus rounding
  localparam int SQ_STEPS = 32;
  localparam int SQ_LAT   = SQ_STEPS + 1;

  // Four 32-bit components, x in the low word
  typedef logic [3:0][31:0] vec_t;

  // Item context carried alongside the square root pipeline
  typedef struct packed {
    func_t       func;
    vec_t        a;
    vec_t        b;
    logic [31:0] d;
    logic        carry;
    logic        kneg;
    vec_t        ear;
    logic [31:0] edr;
    vec_t        refl;
  } ctx_t;

  // Finished result waiting for the normalize quotients
  typedef struct packed {
    vec_t        r;
    logic [31:0] scalar;
    logic        special;
    logic        use_div;
  } res_t;

  // Clamp a wide signed value to the 32-bit range
  function automatic logic signed [31:0] sat32(input logic signed [79:0] v);
    if (v > 80'sd2147483647) begin
      return 32'sh7fff_ffff;
    end else if (v < -80'sd2147483648) begin
      return 32'sh8000_0000;
    end else begin
      return v[31:0];
    end
  endfunction

  // Round an exact product half up to frac fractional bits, then saturate
  function automatic logic signed [31:0] qrnd(input logic signed [63:0] p,
                                              input int unsigned frac);
    logic signed [79:0] t;
    t = (80'(p) + (80'sd1 <<< (frac - 1))) >>> frac;
    return sat32(t);
  endfunction

endpackage

// ===== rtl/core/vec4_geometry_unit.sv =====
// Four-component vector unit over signed fixed point with FRAC_BITS fraction
// bits: length, normalize, dot, reflect and refract.
// Input channel s_axis: one request per handshake, operation code in tuser,
// vectors a, b and eta in tdata. Output channel m_axis: one result per
// request, in request order; vector and scalar in tdata, flag in tuser.
// Throughput: one request per cycle unless the output stalls. Four product lanes
// feed a merging adder, then a 32-stage square root pipeline shared by length,
// normalize and refract, then four FRAC_BITS+1 stage dividers for normalize.
// The whole pipeline advances together; a stalled result in the output
// register holds the pipeline, so s_axis_tready follows m_axis_tready
// while the output register is full.
// Reset clears the valid flags and the output valid; no request is in flight
// after reset and s_axis_tready is high.
module vec4_geometry_unit import v4g_pkg::*; #(
  parameter int FRAC_BITS = 16
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // a_x, a_y, a_z, a_w, b_x, b_y, b_z, b_w, eta (32 bits each)
  input  logic [287:0] s_axis_tdata,
  // func
  input  logic [2:0]   s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // r_x, r_y, r_z, r_w, scalar (32 bits each)
  output logic [159:0] m_axis_tdata,
  // special
  output logic [0:0]   m_axis_tuser
);

  localparam int ResDly = FRAC_BITS + 1;
  localparam int VldN   = 6 + SQ_LAT + 3 + ResDly;
  localparam logic signed [79:0] One = 80'sd1 <<< FRAC_BITS;

  logic            adv, accept;
  logic [VldN:1]   vld_q;
  logic            out_valid_q;
  vec_t            out_r_q;
  logic [31:0]     out_scalar_q;
  logic            out_special_q;

  logic signed [31:0] in_a [4];
  logic signed [31:0] in_b [4];
  logic signed [31:0] in_eta;

  // stage 1
  func_t              func1_q;
  vec_t               a1_q, b1_q;
  logic signed [31:0] eta1_q;
  logic signed [63:0] ee1_q;
  logic        [63:0] aa1 [4];
  logic signed [63:0] ab1 [4];
  logic signed [63:0] ea1 [4];
  // stage 2
  logic [65:0]        sum_sq;
  logic signed [79:0] sum_dot;
  func_t              func2_q;
  vec_t               a2_q, b2_q, ear2_q;
  logic signed [31:0] eta2_q, d2_q, e2_2_q;
  logic [63:0]        sq2_q;
  logic               carry2_q;
  // stage 3
  func_t              func3_q;
  vec_t               a3_q, b3_q, ear3_q;
  logic signed [31:0] d3_q, e2_3_q;
  logic [63:0]        sq3_q;
  logic               carry3_q;
  logic signed [63:0] dd3_q, ed3_q;
  logic signed [63:0] db3_q [4];
  // stage 4
  func_t              func4_q;
  vec_t               a4_q, b4_q, ear4_q, refl4_q;
  logic signed [31:0] d4_q, e2_4_q, u4_q, edr4_q;
  logic [63:0]        sq4_q;
  logic               carry4_q;
  // stage 5
  func_t              func5_q;
  vec_t               a5_q, b5_q, ear5_q, refl5_q;
  logic signed [31:0] d5_q, edr5_q;
  logic [63:0]        sq5_q;
  logic               carry5_q;
  logic signed [63:0] eu5_q;
  // stage 6
  logic signed [79:0] k6;
  logic signed [31:0] ksat6;
  logic               kneg6;
  logic [63:0]        x6_q;
  ctx_t               ctx6_q;
  ctx_t               ctx_line_q [SQ_LAT];
  logic [32:0]        root;
  ctx_t               c39;
  // stage 40
  logic [32:0]        len40_d;
  logic [31:0]        scalar40_d;
  func_t              func40_q;
  vec_t               a40_q, b40_q, ear40_q, refl40_q;
  logic [32:0]        len40_q;
  logic signed [31:0] s40_q;
  logic [31:0]        scalar40_q;
  logic               special40_q;
  logic [31:0]        mag40 [4];
  logic signed [31:0] quo [4];
  // stage 41
  func_t              func41_q;
  vec_t               ear41_q, refl41_q;
  logic [31:0]        scalar41_q;
  logic               special41_q;
  logic signed [63:0] sb41_q [4];
  // stage 42 and delay line
  res_t               res42_d;
  res_t               res42_q;
  res_t               res_line_q [ResDly];
  res_t               res_end;

  // Pipeline advance: output register empty or being drained
  assign adv           = !out_valid_q || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q       <= '0;
      out_valid_q <= 1'b0;
    end else if (adv) begin
      vld_q       <= {vld_q[VldN-1:1], accept};
      out_valid_q <= vld_q[VldN];
    end
  end

  // Unpack the request
  always_comb begin
    for (int i = 0; i < 4; i++) begin
      in_a[i] = $signed(s_axis_tdata[32*i +: 32]);
      in_b[i] = $signed(s_axis_tdata[32*(i+4) +: 32]);
    end
    in_eta = $signed(s_axis_tdata[256 +: 32]);
  end

  // Stage 1: per-lane products
  for (genvar g = 0; g < 4; g++) begin : g_lane
    v4g_lane u_lane (
      .clk_i (clk_i),
      .en_i  (adv),
      .a_i   (in_a[g]),
      .b_i   (in_b[g]),
      .eta_i (in_eta),
      .aa_o  (aa1[g]),
      .ab_o  (ab1[g]),
      .ea_o  (ea1[g])
    );
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      func1_q <= s_axis_tuser;
      a1_q    <= s_axis_tdata[127:0];
      b1_q    <= s_axis_tdata[255:128];
      eta1_q  <= in_eta;
      ee1_q   <= 64'(in_eta) * 64'(in_eta);
    end
  end

  // Stage 2: merge the lanes into the sum of squares and the dot product; round eta^2 and eta*a
  always_comb begin
    sum_sq  = '0;
    sum_dot = '0;
    for (int i = 0; i < 4; i++) begin
      sum_sq  = sum_sq + 66'(aa1[i]);
      sum_dot = sum_dot + 80'(ab1[i]);
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      func2_q  <= func1_q;
      a2_q     <= a1_q;
      b2_q     <= b1_q;
      eta2_q   <= eta1_q;
      sq2_q    <= sum_sq[63:0];
      carry2_q <= |sum_sq[65:64];
      d2_q     <= sat32((sum_dot + (80'sd1 <<< (FRAC_BITS - 1))) >>> FRAC_BITS);
      e2_2_q   <= qrnd(ee1_q, FRAC_BITS);
      for (int i = 0; i < 4; i++) begin
        ear2_q[i] <= qrnd(ea1[i], FRAC_BITS);
      end
    end
  end

  // Stage 3: products with the dot product
  always_ff @(posedge clk_i) begin
    if (adv) begin
      func3_q  <= func2_q;
      a3_q     <= a2_q;
      b3_q     <= b2_q;
      ear3_q   <= ear2_q;
      d3_q     <= d2_q;
      e2_3_q   <= e2_2_q;
      sq3_q    <= sq2_q;
      carry3_q <= carry2_q;
      dd3_q    <= 64'(d2_q) * 64'(d2_q);
      ed3_q    <= 64'(eta2_q) * 64'(d2_q);
      for (int i = 0; i < 4; i++) begin
        db3_q[i] <= 64'(d2_q) * 64'($signed(b2_q[i]));
      end
    end
  end

  // Stage 4: reflect finishes here; 1 - d*d for refract
  always_ff @(posedge clk_i) begin
    if (adv) begin
      func4_q  <= func3_q;
      a4_q     <= a3_q;
      b4_q     <= b3_q;
      ear4_q   <= ear3_q;
      d4_q     <= d3_q;
      e2_4_q   <= e2_3_q;
      sq4_q    <= sq3_q;
      carry4_q <= carry3_q;
      u4_q     <= sat32(One - 80'(qrnd(dd3_q, FRAC_BITS)));
      edr4_q   <= qrnd(ed3_q, FRAC_BITS);
      for (int i = 0; i < 4; i++) begin
        refl4_q[i] <= sat32(80'($signed(a3_q[i])) -
                      ((80'(db3_q[i]) + (80'sd1 <<< (FRAC_BITS - 2))) >>> (FRAC_BITS - 1)));
      end
    end
  end

  // Stage 5: eta^2 * (1 - d^2)
  always_ff @(posedge clk_i) begin
    if (adv) begin
      func5_q  <= func4_q;
      a5_q     <= a4_q;
      b5_q     <= b4_q;
      ear5_q   <= ear4_q;
      refl5_q  <= refl4_q;
      d5_q     <= d4_q;
      edr5_q   <= edr4_q;
      sq5_q    <= sq4_q;
      carry5_q <= carry4_q;
      eu5_q    <= 64'(e2_4_q) * 64'(u4_q);
    end
  end

  // Stage 6: k and the square root operand
  assign k6    = One - 80'(qrnd(eu5_q, FRAC_BITS));
  assign kneg6 = k6[79];
  assign ksat6 = sat32(k6);

  always_ff @(posedge clk_i) begin
    if (adv) begin
      if (func5_q == FUNC_REFR) begin
        x6_q <= kneg6 ? '0 : (64'($unsigned(ksat6)) << FRAC_BITS);
      end else begin
        x6_q <= sq5_q;
      end
      ctx6_q.func  <= func5_q;
      ctx6_q.a     <= a5_q;
      ctx6_q.b     <= b5_q;
      ctx6_q.d     <= d5_q;
      ctx6_q.carry <= carry5_q;
      ctx6_q.kneg  <= kneg6;
      ctx6_q.ear   <= ear5_q;
      ctx6_q.edr   <= edr5_q;
      ctx6_q.refl  <= refl5_q;
    end
  end

  // Shared square root, context travels alongside
  v4g_sqrt u_sqrt (
    .clk_i  (clk_i),
    .en_i   (adv),
    .x_i    (x6_q),
    .root_o (root)
  );

  always_ff @(posedge clk_i) begin
    if (adv) begin
      ctx_line_q[0] <= ctx6_q;
      for (int j = 1; j < SQ_LAT; j++) begin
        ctx_line_q[j] <= ctx_line_q[j-1];
      end
    end
  end

  assign c39 = ctx_line_q[SQ_LAT-1];

  // Stage 40: length, refract scale s, scalar result and flag
  always_comb begin
    len40_d = c39.carry ? 33'h1_0000_0000 : root;
    case (c39.func)
      FUNC_LEN, FUNC_NORM: scalar40_d = (len40_d > 33'h0_7fff_ffff) ?
                                        32'h7fff_ffff : len40_d[31:0];
      FUNC_DOT:            scalar40_d = c39.d;
      default:             scalar40_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      func40_q    <= c39.func;
      a40_q       <= c39.a;
      b40_q       <= c39.b;
      ear40_q     <= c39.ear;
      refl40_q    <= c39.refl;
      len40_q     <= len40_d;
      s40_q       <= sat32(80'($signed(c39.edr)) + 80'($signed({1'b0, root})));
      scalar40_q  <= scalar40_d;
      special40_q <= ((c39.func == FUNC_NORM) && (len40_d == '0)) ||
                     ((c39.func == FUNC_REFR) && c39.kneg);
    end
  end

  // Normalize dividers, one per lane
  for (genvar g = 0; g < 4; g++) begin : g_div
    assign mag40[g] = a40_q[g][31] ? (~a40_q[g] + 32'd1) : a40_q[g];

    v4g_div #(
      .FRAC_BITS (FRAC_BITS)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (adv),
      .mag_i (mag40[g]),
      .neg_i (a40_q[g][31]),
      .len_i (len40_q),
      .quo_o (quo[g])
    );
  end

  // Stage 41: s * b
  always_ff @(posedge clk_i) begin
    if (adv) begin
      func41_q    <= func40_q;
      ear41_q     <= ear40_q;
      refl41_q    <= refl40_q;
      scalar41_q  <= scalar40_q;
      special41_q <= special40_q;
      for (int i = 0; i < 4; i++) begin
        sb41_q[i] <= 64'(s40_q) * 64'($signed(b40_q[i]));
      end
    end
  end

  // Stage 42: select the result vector by operation
  always_comb begin
    res42_d.r       = '0;
    res42_d.scalar  = scalar41_q;
    res42_d.special = special41_q;
    res42_d.use_div = 1'b0;
    case (func41_q)
      FUNC_NORM: res42_d.use_div = !special41_q;
      FUNC_REFL: res42_d.r = refl41_q;
      FUNC_REFR: begin
        if (!special41_q) begin
          for (int i = 0; i < 4; i++) begin
            res42_d.r[i] = sat32(80'($signed(ear41_q[i])) -
                                 80'(qrnd(sb41_q[i], FRAC_BITS)));
          end
        end
      end
      default: res42_d.r = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (adv) begin
      res42_q       <= res42_d;
      res_line_q[0] <= res42_q;
      for (int j = 1; j < ResDly; j++) begin
        res_line_q[j] <= res_line_q[j-1];
      end
    end
  end

  assign res_end = res_line_q[ResDly-1];

  // Output register
  always_ff @(posedge clk_i) begin
    if (adv) begin
      out_scalar_q  <= res_end.scalar;
      out_special_q <= res_end.special;
      for (int i = 0; i < 4; i++) begin
        out_r_q[i] <= res_end.use_div ? quo[i] : res_end.r[i];
      end
    end
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {out_scalar_q, out_r_q[3], out_r_q[2], out_r_q[1], out_r_q[0]};
  assign m_axis_tuser  = out_special_q;

endmodule

// ===== rtl/core/v4g_lane.sv =====
module v4g_lane (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic signed [31:0] a_i,
  input  logic signed [31:0] b_i,
  input  logic signed [31:0] eta_i,
  output logic        [63:0] aa_o,
  output logic signed [63:0] ab_o,
  output logic signed [63:0] ea_o
);

  logic signed [63:0] ax, bx, ex;
  logic        [63:0] aa_q;
  logic signed [63:0] ab_q, ea_q;

  assign ax = 64'(a_i);
  assign bx = 64'(b_i);
  assign ex = 64'(eta_i);

  // Exact per-component products: square, cross term and eta scaling
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      aa_q <= $unsigned(ax * ax);
      ab_q <= ax * bx;
      ea_q <= ex * ax;
    end
  end

  assign aa_o = aa_q;
  assign ab_o = ab_q;
  assign ea_o = ea_q;

endmodule

// ===== rtl/core/v4g_sqrt.sv =====
module v4g_sqrt import v4g_pkg::*; (
  input  logic        clk_i,
  input  logic        en_i,
  input  logic [63:0] x_i,
  output logic [32:0] root_o
);

  logic [63:0] rem_in [SQ_STEPS];
  logic [63:0] r_in   [SQ_STEPS];
  logic [63:0] trial  [SQ_STEPS];
  logic [63:0] bitv   [SQ_STEPS];
  logic [63:0] rem_d  [SQ_STEPS];
  logic [63:0] r_d    [SQ_STEPS];
  logic [63:0] rem_q  [SQ_STEPS];
  logic [63:0] r_q    [SQ_STEPS];
  logic [32:0] root_q;

  // One root bit per stage, restoring digit recurrence
  always_comb begin
    rem_in[0] = x_i;
    r_in[0]   = '0;
    for (int j = 1; j < SQ_STEPS; j++) begin
      rem_in[j] = rem_q[j-1];
      r_in[j]   = r_q[j-1];
    end
    for (int j = 0; j < SQ_STEPS; j++) begin
      bitv[j]  = 64'd1 << (62 - 2 * j);
      trial[j] = r_in[j] + bitv[j];
      if (rem_in[j] >= trial[j]) begin
        rem_d[j] = rem_in[j] - trial[j];
        r_d[j]   = (r_in[j] >> 1) + bitv[j];
      end else begin
        rem_d[j] = rem_in[j];
        r_d[j]   = r_in[j] >> 1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < SQ_STEPS; j++) begin
        rem_q[j] <= rem_d[j];
        r_q[j]   <= r_d[j];
      end
      // round to nearest: remainder above the root means the next integer is closer
      root_q <= (rem_q[SQ_STEPS-1] > r_q[SQ_STEPS-1]) ?
                r_q[SQ_STEPS-1][32:0] + 33'd1 : r_q[SQ_STEPS-1][32:0];
    end
  end

  assign root_o = root_q;

endmodule

// ===== rtl/core/v4g_div.sv =====
module v4g_div #(
  parameter int FRAC_BITS = 16
) (
  input  logic               clk_i,
  input  logic               en_i,
  input  logic        [31:0] mag_i,
  input  logic               neg_i,
  input  logic        [32:0] len_i,
  output logic signed [31:0] quo_o
);

  localparam int QW = FRAC_BITS + 1;
  localparam int NW = 32 + FRAC_BITS;

  logic [NW-1:0] n_q;
  logic [32:0]   len0_q;
  logic          neg0_q;

  logic [32:0]   rem_in [QW];
  logic [QW-1:0] nlo_in [QW];
  logic [QW-1:0] quo_in [QW];
  logic [32:0]   len_in [QW];
  logic          neg_in [QW];
  logic [33:0]   sh     [QW];
  logic [32:0]   rem_d  [QW];
  logic [QW-1:0] quo_d  [QW];
  logic [32:0]   rem_q  [QW];
  logic [QW-1:0] nlo_q  [QW];
  logic [QW-1:0] quo_q  [QW];
  logic [32:0]   len_q  [QW];
  logic          neg_q  [QW];
  logic signed [31:0] out_q;

  // Numerator with half the divisor added for round half away from zero
  always_ff @(posedge clk_i) begin
    if (en_i) begin
      n_q    <= (NW'(mag_i) << FRAC_BITS) + NW'(len_i >> 1);
      len0_q <= len_i;
      neg0_q <= neg_i;
    end
  end

  // One quotient bit per stage
  always_comb begin
    rem_in[0] = 33'(n_q >> QW);
    nlo_in[0] = n_q[QW-1:0];
    quo_in[0] = '0;
    len_in[0] = len0_q;
    neg_in[0] = neg0_q;
    for (int j = 1; j < QW; j++) begin
      rem_in[j] = rem_q[j-1];
      nlo_in[j] = nlo_q[j-1];
      quo_in[j] = quo_q[j-1];
      len_in[j] = len_q[j-1];
      neg_in[j] = neg_q[j-1];
    end
    for (int j = 0; j < QW; j++) begin
      sh[j] = {rem_in[j], nlo_in[j][QW-1]};
      if (sh[j] >= {1'b0, len_in[j]}) begin
        rem_d[j] = 33'(sh[j] - {1'b0, len_in[j]});
        quo_d[j] = {quo_in[j][QW-2:0], 1'b1};
      end else begin
        rem_d[j] = sh[j][32:0];
        quo_d[j] = {quo_in[j][QW-2:0], 1'b0};
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int j = 0; j < QW; j++) begin
        rem_q[j] <= rem_d[j];
        nlo_q[j] <= nlo_in[j] << 1;
        quo_q[j] <= quo_d[j];
        len_q[j] <= len_in[j];
        neg_q[j] <= neg_in[j];
      end
      // quotient never exceeds one, so the sign applies without overflow
      out_q <= neg_q[QW-1] ? -$signed(32'(quo_q[QW-1])) : $signed(32'(quo_q[QW-1]));
    end
  end

  assign quo_o = out_q;

endmodule

// ===== bench/testbench.sv =====
`timescale 1ns / 100ps

module testbench import v4g_pkg::*;;

  localparam int FB = 16;
  localparam logic signed [31:0] ONE = 32'sh0001_0000;

  typedef logic signed [127:0] wide_t;

  // One request: operation, vectors and ratio
  typedef struct packed {
    func_t       func;
    vec_t        a;
    vec_t        b;
    logic [31:0] eta;
  } geo_req_t;

  // One result: vector, scalar and flag
  typedef struct packed {
    vec_t        r;
    logic [31:0] scalar;
    logic        special;
  } geo_res_t;

  logic         clk_i = 1'b0;
  logic         rst_ni = 1'b0;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [287:0] s_axis_tdata = '0;
  logic [2:0]   s_axis_tuser = '0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [159:0] m_axis_tdata;
  logic [0:0]   m_axis_tuser;

  geo_res_t expected_results[$];
  int       error_count = 0;
  bit       idle_on = 1'b0;
  int       sink_hold = 0;

  vec4_geometry_unit #(.FRAC_BITS(FB)) u_top (
    .clk_i, .rst_ni,
    .s_axis_tvalid, .s_axis_tready, .s_axis_tdata, .s_axis_tuser,
    .m_axis_tvalid, .m_axis_tready, .m_axis_tdata, .m_axis_tuser
  );

  always #10 clk_i = ~clk_i;

  // Fixed-point helpers
  function automatic wide_t clamp32(input wide_t v);
    if (v > 128'sd2147483647) return 128'sd2147483647;
    if (v < -128'sd2147483648) return -128'sd2147483648;
    return v;
  endfunction

  function automatic wide_t fx_mul(input wide_t x, input wide_t y);
    return clamp32((x * y + (128'sd1 <<< (FB - 1))) >>> FB);
  endfunction

  function automatic wide_t fx_dot(input vec_t x, input vec_t y);
    wide_t acc;
    acc = 0;
    for (int i = 0; i < 4; i++) begin
      acc += wide_t'($signed(x[i])) * wide_t'($signed(y[i]));
    end
    return clamp32((acc + (128'sd1 <<< (FB - 1))) >>> FB);
  endfunction

  // Square root rounded to nearest, ties up
  function automatic logic [65:0] round_sqrt(input logic [65:0] x);
    logic [65:0] rem, root, bitv;
    rem = x;
    root = 0;
    bitv = 66'd1 << 64;
    while (bitv > rem) bitv >>= 2;
    while (bitv != 0) begin
      if (rem >= root + bitv) begin
        rem -= root + bitv;
        root = (root >> 1) + bitv;
      end else begin
        root >>= 1;
      end
      bitv >>= 2;
    end
    if (x - root * root > root) root++;
    return root;
  endfunction

  // Predict the result of one request
  function automatic geo_res_t geometry_result(input geo_req_t q);
    geo_res_t    res;
    logic [65:0] sum, len, mag, quo;
    wide_t       d, u, k, sk, s, eta, ai, t;
    res = '0;
    eta = wide_t'($signed(q.eta));
    case (q.func)
      FUNC_LEN, FUNC_NORM: begin
        sum = 0;
        for (int i = 0; i < 4; i++) begin
          ai = wide_t'($signed(q.a[i]));
          sum += 66'(ai * ai);
        end
        len = (sum >= (66'd1 << 64)) ? (66'd1 << 32) : round_sqrt(sum);
        res.scalar = (len > 66'd2147483647) ? 32'h7fff_ffff : len[31:0];
        if (q.func == FUNC_NORM) begin
          if (len == 0) begin
            res.special = 1'b1;
          end else begin
            for (int i = 0; i < 4; i++) begin
              ai = wide_t'($signed(q.a[i]));
              mag = 66'(ai < 0 ? -ai : ai);
              quo = ((mag << FB) + len / 2) / len;
              t = wide_t'(quo);
              res.r[i] = 32'(clamp32(ai < 0 ? -t : t));
            end
          end
        end
      end
      FUNC_DOT: res.scalar = 32'(fx_dot(q.a, q.b));
      FUNC_REFL: begin
        d = fx_dot(q.b, q.a);
        for (int i = 0; i < 4; i++) begin
          t = (d * wide_t'($signed(q.b[i])) + (128'sd1 <<< (FB - 2))) >>> (FB - 1);
          res.r[i] = 32'(clamp32(wide_t'($signed(q.a[i])) - t));
        end
      end
      FUNC_REFR: begin
        d = fx_dot(q.b, q.a);
        u = clamp32(ONE - fx_mul(d, d));
        k = ONE - fx_mul(fx_mul(eta, eta), u);
        if (k < 0) begin
          res.special = 1'b1;
        end else begin
          sk = wide_t'(round_sqrt(66'(clamp32(k)) << FB));
          s = clamp32(fx_mul(eta, d) + sk);
          for (int i = 0; i < 4; i++) begin
            res.r[i] = 32'(clamp32(fx_mul(eta, wide_t'($signed(q.a[i])))
                                   - fx_mul(s, wide_t'($signed(q.b[i])))));
          end
        end
      end
      default: res = '0;
    endcase
    return res;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h expected %h at %0t", what, got, want, $time);
    error_count++;
  endtask

  // Send one request and record its expected result on acceptance
  task automatic send_request(input geo_req_t q);
    if (idle_on && $urandom_range(99) < 13) begin
      s_axis_tvalid <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < 13);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser  <= q.func;
    s_axis_tdata  <= {q.eta, q.b, q.a};
    do @(posedge clk_i); while (!s_axis_tready);
    expected_results.push_back(geometry_result(q));
  endtask

  task automatic wait_drained();
    s_axis_tvalid <= 1'b0;
    while (expected_results.size() != 0) @(posedge clk_i);
  endtask

  // Sink side: random stalls plus an optional long hold
  always @(posedge clk_i) begin
    if (sink_hold > 0) begin
      sink_hold <= sink_hold - 1;
      m_axis_tready <= 1'b0;
    end else begin
      m_axis_tready <= !(idle_on && $urandom_range(99) < 13);
    end
  end

  // Result checker
  always @(posedge clk_i) begin
    geo_res_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (expected_results.size() == 0) begin
        report_mismatch("unexpected result", m_axis_tdata[31:0], '0);
      end else begin
        want = expected_results.pop_front();
        for (int i = 0; i < 4; i++) begin
          if (m_axis_tdata[32*i +: 32] !== want.r[i])
            report_mismatch($sformatf("r[%0d]", i), m_axis_tdata[32*i +: 32], want.r[i]);
        end
        if (m_axis_tdata[159:128] !== want.scalar)
          report_mismatch("scalar", m_axis_tdata[159:128], want.scalar);
        if (m_axis_tuser[0] !== want.special)
          report_mismatch("special", 32'(m_axis_tuser[0]), 32'(want.special));
      end
    end
  end

  // Random component: full range, small magnitudes or extremes
  function automatic logic [31:0] rand_word();
    case ($urandom_range(5))
      0, 1: return $urandom();
      2, 3: return 32'($signed($urandom_range(8 * 65536)) - 4 * 65536);
      4: return 32'($signed($urandom_range(512)) - 256);
      default: begin
        case ($urandom_range(3))
          0: return 32'h7fff_ffff;
          1: return 32'h8000_0000;
          2: return ONE;
          default: return -ONE;
        endcase
      end
    endcase
  endfunction

  function automatic geo_req_t rand_request();
    geo_req_t q;
    q.func = ($urandom_range(19) == 0) ? func_t'($urandom_range(7))
                                       : func_t'($urandom_range(FUNC_REFR));
    for (int i = 0; i < 4; i++) begin
      q.a[i] = rand_word();
      q.b[i] = rand_word();
    end
    // unit axis normal and modest ratio, so refract often gets past k < 0
    if ($urandom_range(1)) begin
      q.b = '0;
      q.b[2'($urandom_range(3))] = $urandom_range(1) ? ONE : -ONE;
      for (int i = 0; i < 4; i++) q.a[i] = 32'($signed($urandom_range(2 * 65536)) - 65536);
    end
    q.eta = $urandom_range(2) ? 32'($urandom_range(2 * 65536)) : rand_word();
    return q;
  endfunction

  function automatic geo_req_t make_req(input func_t f, input logic [31:0] av,
                                        input logic [31:0] bv, input logic [31:0] e);
    geo_req_t q;
    q.func = f;
    q.a = {4{av}};
    q.b = {4{bv}};
    q.eta = e;
    return q;
  endfunction

  task automatic test_directed();
    geo_req_t q;
    send_request(make_req(FUNC_LEN, 32'h8000_0000, 0, 0));
    send_request(make_req(FUNC_LEN, 32'h7fff_ffff, 0, 0));
    send_request(make_req(FUNC_LEN, 0, 0, 0));
    send_request(make_req(FUNC_NORM, 0, 0, 0));
    send_request(make_req(FUNC_NORM, 32'h8000_0000, 0, 0));
    send_request(make_req(FUNC_NORM, 1, 0, 0));
    send_request(make_req(FUNC_DOT, 32'h7fff_ffff, 32'h7fff_ffff, 0));
    send_request(make_req(FUNC_DOT, 32'h8000_0000, 32'h7fff_ffff, 0));
    send_request(make_req(FUNC_REFL, 32'h7fff_ffff, 32'h8000_0000, 0));
    send_request(make_req(FUNC_REFL, ONE, ONE, 0));
    // refract: grazing incidence with eta 2 is total internal reflection
    q = make_req(FUNC_REFR, 0, 0, 2 * ONE);
    q.a[0] = ONE;
    q.b[1] = ONE;
    send_request(q);
    q.eta = ONE;
    send_request(q);
    q.eta = 32'h8000_0000;
    send_request(q);
    send_request(make_req(FUNC_REFR, ONE >>> 1, -ONE, ONE >>> 1));
    send_request(make_req(FUNC_REFR, 32'h7fff_ffff, 32'h7fff_ffff, 32'h7fff_ffff));
    for (int f = FUNC_REFR + 1; f < 8; f++)
      send_request(make_req(func_t'(f), 32'hffff_ffff, 32'hffff_ffff, 32'hffff_ffff));
    wait_drained();
  endtask

  task automatic test_random(input int count, input bit with_idle);
    idle_on = with_idle;
    repeat (count) send_request(rand_request());
  endtask

  task automatic test_backpressure();
    idle_on = 1'b0;
    sink_hold = 300;
    repeat (150) send_request(rand_request());
    wait_drained();
  endtask

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end

  initial begin
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    test_directed();
    test_random(600, 1'b1);
    test_random(300, 1'b0);
    test_backpressure();
    test_random(700, 1'b1);
    wait_drained();
    repeat (80) @(posedge clk_i);
    if (error_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

// ===== sim.f =====
rtl/core/v4g_pkg.sv
rtl/core/v4g_lane.sv
rtl/core/v4g_sqrt.sv
rtl/core/v4g_div.sv
rtl/core/vec4_geometry_unit.sv
bench/testbench.sv
